>>> design/pts_pkg.sv
`timescale 1ns / 1ps

package pts_pkg;

  // Default table size
  localparam int TASK_SLOTS_DEF = 8;
  // Most run results that one dispatch hands out
  localparam int MAX_RESULTS = 8;

  // Request function codes
  localparam logic [1:0] FUNC_ADD  = 2'd0;
  localparam logic [1:0] FUNC_DEL  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;
  localparam logic [1:0] FUNC_DISP = 2'd3;

  // Response kind codes
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_DEL  = 2'd1;
  localparam logic [1:0] KIND_RUN  = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  // Response status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  slot_id;
    logic [7:0]  task_tag;
    logic [15:0] first_delay;
    logic [15:0] run_period;
  } req_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic [7:0] tag;
    logic       status;
    logic       last;
  } rsp_item_t;

endpackage

>>> design/pts_req_if.sv
`timescale 1ns / 1ps

interface pts_req_if;
  logic               valid;
  logic               ready;
  pts_pkg::req_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> design/pts_rsp_if.sv
`timescale 1ns / 1ps

interface pts_rsp_if;
  logic               valid;
  logic               ready;
  pts_pkg::rsp_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> design/periodic_task_slot_scheduler.sv
`timescale 1ns / 1ps
// Add and rejected delete answer from the closing state when the output is free.
// Tick walks the active slots one per cycle.
// Delete shifts one slot per cycle; dispatch walks one slot per cycle plus a shift
// pass per removed one-shot task, and waits whenever the response register is held.
// One item at a time; tick, dispatch and shift go through one shared slot read/update unit.
// Reset (rst, synchronous): table empty, sequencer idle, no response pending.
module periodic_task_slot_scheduler #(
  parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  pts_req_if.sink    req,
  pts_rsp_if.source  rsp
);

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int NW = $clog2(pts_pkg::MAX_RESULTS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TICK  = 5'b00010,
    S_DISP  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_FINAL = 5'b10000
  } state_t;

  // Slot table
  logic [15:0] countdown [TASK_SLOTS];
  logic [15:0] period    [TASK_SLOTS];
  logic [7:0]  pending   [TASK_SLOTS];
  logic [7:0]  task_tags [TASK_SLOTS];

  state_t             state;
  logic [CW-1:0]      task_count;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      sh;
  logic [NW-1:0]      n;
  logic               disp;
  logic               hold_valid;
  pts_pkg::rsp_item_t hold;
  logic               out_valid;
  pts_pkg::rsp_item_t out_item;

  // Shared read port and update unit
  logic [CW-1:0] rd_ptr;
  logic [IW-1:0] rd;
  logic [15:0]   rd_cd;
  logic [15:0]   rd_per;
  logic [7:0]    rd_pend;
  logic [7:0]    rd_tag;
  logic [15:0]   cd_dec;
  logic [7:0]    pend_inc;
  logic [7:0]    pend_dec;
  logic [CW-1:0] sh_inc;
  logic          idx_live;
  logic          out_free;
  logic          n_open;
  logic          disp_go;
  logic          out_load;

  assign sh_inc   = sh + 1'b1;
  assign rd_ptr   = (state == S_SHIFT) ? sh_inc : idx;
  assign rd       = rd_ptr[IW-1:0];
  assign rd_cd    = countdown[rd];
  assign rd_per   = period[rd];
  assign rd_pend  = pending[rd];
  assign rd_tag   = task_tags[rd];
  assign cd_dec   = rd_cd - 16'd1;
  assign pend_inc = (rd_pend == 8'hFF) ? rd_pend : rd_pend + 8'd1;
  assign pend_dec = rd_pend - 8'd1;
  assign idx_live = idx < task_count;
  assign out_free = !out_valid || rsp.ready;
  assign n_open   = 32'(n) < pts_pkg::MAX_RESULTS;

  // A run is taken when the slot has a run pending, the cap is not reached and the held run can move on
  assign disp_go  = (state == S_DISP) && idx_live && n_open && (rd_pend != 8'd0)
                    && (!hold_valid || out_free);
  assign out_load = ((state == S_FINAL) && out_free) || (disp_go && hold_valid);

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_item;

  // Sequencer, table updates and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      task_count <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
      sh         <= '0;
      n          <= '0;
      disp       <= 1'b0;
    end else begin
      // Response register: load a new transfer or drop the one taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            hold.tag    <= 8'd0;
            hold.last   <= 1'b0;
            unique case (req.payload.func)
              pts_pkg::FUNC_ADD: begin
                hold.kind  <= pts_pkg::KIND_ADD;
                hold_valid <= 1'b1;
                if (32'(task_count) < TASK_SLOTS) begin
                  countdown[task_count[IW-1:0]] <= req.payload.first_delay;
                  period[task_count[IW-1:0]]    <= req.payload.run_period;
                  pending[task_count[IW-1:0]]   <= 8'd0;
                  task_tags[task_count[IW-1:0]] <= req.payload.task_tag;
                  task_count  <= task_count + 1'b1;
                  hold.slot   <= 4'(task_count);
                  hold.status <= pts_pkg::STATUS_OK;
                end else begin
                  hold.slot   <= 4'(TASK_SLOTS);
                  hold.status <= pts_pkg::STATUS_ERR;
                end
                state <= S_FINAL;
              end
              pts_pkg::FUNC_DEL: begin
                hold.kind  <= pts_pkg::KIND_DEL;
                hold.slot  <= 4'(req.payload.slot_id);
                hold_valid <= 1'b1;
                disp       <= 1'b0;
                if (32'(req.payload.slot_id) < 32'(task_count)) begin
                  hold.status <= pts_pkg::STATUS_OK;
                  sh          <= CW'(req.payload.slot_id);
                  state       <= S_SHIFT;
                end else begin
                  hold.status <= pts_pkg::STATUS_ERR;
                  state       <= S_FINAL;
                end
              end
              pts_pkg::FUNC_TICK: begin
                idx        <= '0;
                state      <= S_TICK;
              end
              default: begin
                idx        <= '0;
                n          <= '0;
                disp       <= 1'b1;
                state      <= S_DISP;
              end
            endcase
          end
        end

        // One active slot per cycle: count down or reload and add a run
        S_TICK: begin
          if (idx_live) begin
            if (rd_cd != 16'd0) begin
              countdown[rd] <= cd_dec;
            end else begin
              countdown[rd] <= rd_per;
              pending[rd]   <= pend_inc;
            end
            idx <= idx + 1'b1;
          end else begin
            state <= S_FINAL;
          end
        end

        // Walk slots; the newest run is held back so the final one can carry last
        S_DISP: begin
          if (!idx_live || !n_open) begin
            state <= S_FINAL;
          end else if (rd_pend == 8'd0) begin
            idx <= idx + 1'b1;
          end else if (disp_go) begin
            if (hold_valid) begin
              out_item <= hold;
            end
            hold.kind   <= pts_pkg::KIND_RUN;
            hold.slot   <= 4'(idx);
            hold.tag    <= rd_tag;
            hold.status <= pts_pkg::STATUS_OK;
            hold.last   <= 1'b0;
            hold_valid  <= 1'b1;
            n           <= n + 1'b1;
            pending[rd] <= pend_dec;
            if (rd_per == 16'd0) begin
              sh    <= idx;
              state <= S_SHIFT;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        // Compact the table down over slot sh, one slot per cycle
        S_SHIFT: begin
          if (sh_inc < task_count) begin
            countdown[sh[IW-1:0]] <= rd_cd;
            period[sh[IW-1:0]]    <= rd_per;
            pending[sh[IW-1:0]]   <= rd_pend;
            task_tags[sh[IW-1:0]] <= rd_tag;
            sh                    <= sh_inc;
          end else begin
            task_count <= task_count - 1'b1;
            state      <= disp ? S_DISP : S_FINAL;
          end
        end

        // Hand over the closing response
        S_FINAL: begin
          if (out_free) begin
            if (hold_valid) begin
              out_item <= {hold.kind, hold.slot, hold.tag, hold.status, 1'b1};
            end else begin
              out_item.kind   <= pts_pkg::KIND_NONE;
              out_item.slot   <= 4'd0;
              out_item.tag    <= 8'd0;
              out_item.status <= pts_pkg::STATUS_OK;
              out_item.last   <= 1'b1;
            end
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(task_count) <= TASK_SLOTS)
    else $error("task count beyond table size");

  a_run_cap: assert property (@(posedge clk) disable iff (rst)
    32'(n) <= pts_pkg::MAX_RESULTS)
    else $error("dispatch result count beyond cap");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINAL) && out_free |=> rsp.valid && rsp.payload.last)
    else $error("closing response missing or not marked last");

  a_tick_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK) |-> !hold_valid)
    else $error("held run during tick walk");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && (req.payload.func == pts_pkg::FUNC_ADD)
      && (32'(task_count) < TASK_SLOTS)
    |=> task_count == $past(task_count) + 1'b1)
    else $error("add did not grow the table");

endmodule

>>> tb/tb_periodic_task_slot_scheduler.sv
`timescale 1ns / 1ps

module tb_periodic_task_slot_scheduler;

  localparam int SLOTS       = pts_pkg::TASK_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;

  // Predicts scheduler responses and checks them in order
  class sched_scoreboard;
    bit          active[SLOTS];
    bit [15:0]   count_left[SLOTS];
    bit [15:0]   reload[SLOTS];
    bit [7:0]    runs_due[SLOTS];
    bit [7:0]    tags[SLOTS];
    int unsigned n_tasks;

    pts_pkg::rsp_item_t expected_rsp_q[$];
    int          errors;
    int          n_req[4];
    int          n_rsp;
    int          n_runs;

    function pts_pkg::rsp_item_t make_rsp(logic [1:0] k, logic [3:0] s, logic [7:0] t,
                                          logic st, logic l);
      pts_pkg::rsp_item_t r;
      r.kind   = k;
      r.slot   = s;
      r.tag    = t;
      r.status = st;
      r.last   = l;
      return r;
    endfunction

    // Remove one slot, pull later slots down, clear the vacated top slot
    function void drop_slot(int unsigned id);
      int unsigned i;
      for (i = id; i + 1 < n_tasks; i++) begin
        active[i]     = active[i + 1];
        count_left[i] = count_left[i + 1];
        reload[i]     = reload[i + 1];
        runs_due[i]   = runs_due[i + 1];
        tags[i]       = tags[i + 1];
      end
      n_tasks--;
      active[n_tasks]     = 1'b0;
      count_left[n_tasks] = '0;
      reload[n_tasks]     = '0;
      runs_due[n_tasks]   = '0;
      tags[n_tasks]       = '0;
    endfunction

    // Update the table for an accepted request and queue its responses
    function void note_request(pts_pkg::req_item_t r);
      pts_pkg::rsp_item_t batch[$];
      int unsigned i;
      int          n;
      bit          removed;
      n_req[r.func]++;
      case (r.func)
        pts_pkg::FUNC_ADD: begin
          if (n_tasks < SLOTS) begin
            active[n_tasks]     = 1'b1;
            count_left[n_tasks] = r.first_delay;
            reload[n_tasks]     = r.run_period;
            runs_due[n_tasks]   = '0;
            tags[n_tasks]       = r.task_tag;
            batch.push_back(make_rsp(pts_pkg::KIND_ADD, 4'(n_tasks), 8'd0,
                                     pts_pkg::STATUS_OK, 1'b1));
            n_tasks++;
          end else begin
            batch.push_back(make_rsp(pts_pkg::KIND_ADD, 4'(SLOTS), 8'd0,
                                     pts_pkg::STATUS_ERR, 1'b1));
          end
        end
        pts_pkg::FUNC_DEL: begin
          if (32'(r.slot_id) < n_tasks) begin
            drop_slot(32'(r.slot_id));
            batch.push_back(make_rsp(pts_pkg::KIND_DEL, 4'(r.slot_id), 8'd0,
                                     pts_pkg::STATUS_OK, 1'b1));
          end else begin
            batch.push_back(make_rsp(pts_pkg::KIND_DEL, 4'(r.slot_id), 8'd0,
                                     pts_pkg::STATUS_ERR, 1'b1));
          end
        end
        pts_pkg::FUNC_TICK: begin
          // count down, or reload and make a run pending (saturating)
          for (i = 0; i < SLOTS; i++) begin
            if (active[i]) begin
              if (count_left[i] > 0) begin
                count_left[i]--;
              end else begin
                count_left[i] = reload[i];
                if (runs_due[i] < 8'd255) runs_due[i]++;
              end
            end
          end
          batch.push_back(make_rsp(pts_pkg::KIND_NONE, 4'd0, 8'd0,
                                   pts_pkg::STATUS_OK, 1'b1));
        end
        default: begin
          // walk slots; a one-shot is removed and its successor seen in place
          i = 0;
          n = 0;
          while (i < n_tasks && n < pts_pkg::MAX_RESULTS) begin
            removed = 1'b0;
            if (runs_due[i] > 0) begin
              runs_due[i]--;
              batch.push_back(make_rsp(pts_pkg::KIND_RUN, 4'(i), tags[i],
                                       pts_pkg::STATUS_OK, 1'b0));
              n++;
              if (reload[i] == 0) begin
                drop_slot(i);
                removed = 1'b1;
              end
            end
            if (!removed) i++;
          end
          n_runs += n;
          if (n == 0) batch.push_back(make_rsp(pts_pkg::KIND_NONE, 4'd0, 8'd0,
                                               pts_pkg::STATUS_OK, 1'b1));
          else batch[batch.size() - 1].last = 1'b1;
        end
      endcase
      foreach (batch[k]) expected_rsp_q.push_back(batch[k]);
    endfunction

    function void compare_field(string name, logic [7:0] exp, logic [7:0] act);
      if (act !== exp) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
        errors++;
      end
    endfunction

    function void check_response(pts_pkg::rsp_item_t got);
      pts_pkg::rsp_item_t e;
      n_rsp++;
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected response: kind %0d slot %0d tag %0d status %0d last %0d",
               got.kind, got.slot, got.tag, got.status, got.last);
        errors++;
        return;
      end
      e = expected_rsp_q.pop_front();
      compare_field("kind", 8'(e.kind), 8'(got.kind));
      compare_field("slot", 8'(e.slot), 8'(got.slot));
      compare_field("tag", e.tag, got.tag);
      compare_field("status", 8'(e.status), 8'(got.status));
      compare_field("last", 8'(e.last), 8'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst;

  pts_req_if req_if ();
  pts_rsp_if rsp_if ();

  periodic_task_slot_scheduler uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  sched_scoreboard board;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int hold_left;
  int cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycles, board.expected_rsp_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Response side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready = 1'b0;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every response transfer
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) board.check_response(rsp_if.payload);
  end

  // One request transfer, with random idle cycles ahead of it
  task automatic send_request(pts_pkg::req_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid   = 1'b1;
    req_if.payload = item;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    board.note_request(item);
    @(negedge clk);
    req_if.valid = 1'b0;
  endtask

  task automatic send_fields(logic [1:0] func, logic [2:0] sid, logic [7:0] tag,
                             logic [15:0] delay, logic [15:0] per);
    pts_pkg::req_item_t item;
    item.func        = func;
    item.slot_id     = sid;
    item.task_tag    = tag;
    item.first_delay = delay;
    item.run_period  = per;
    send_request(item);
  endtask

  task automatic wait_drain();
    while (board.expected_rsp_q.size() != 0) @(negedge clk);
  endtask

  // Mostly short delays and periods so tasks actually run; some noise
  function automatic pts_pkg::req_item_t random_request();
    pts_pkg::req_item_t item;
    logic [63:0]        noise;
    int                 roll;
    noise = {$urandom, $urandom};
    item  = noise[$bits(pts_pkg::req_item_t)-1:0];
    if ($urandom_range(99) < 8) return item;
    roll = $urandom_range(99);
    if (roll < 20) item.func = pts_pkg::FUNC_ADD;
    else if (roll < 32) item.func = pts_pkg::FUNC_DEL;
    else if (roll < 72) item.func = pts_pkg::FUNC_TICK;
    else item.func = pts_pkg::FUNC_DISP;
    if ($urandom_range(99) < 80) item.first_delay = 16'($urandom_range(0, 4));
    if ($urandom_range(99) < 30) item.run_period = '0;
    else if ($urandom_range(99) < 85) item.run_period = 16'($urandom_range(1, 4));
    return item;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_request(random_request());
  endtask

  task automatic run_directed();
    // dispatch and delete on an empty table
    send_fields(pts_pkg::FUNC_DISP, 3'd0, 8'h00, 16'd0, 16'd0);
    send_fields(pts_pkg::FUNC_DEL, 3'd0, 8'h00, 16'd0, 16'd0);
    // one-shot that runs on the next tick, then widest delay and period
    send_fields(pts_pkg::FUNC_ADD, 3'd7, 8'hFF, 16'd0, 16'd0);
    send_fields(pts_pkg::FUNC_ADD, 3'd0, 8'h00, 16'hFFFF, 16'hFFFF);
    send_fields(pts_pkg::FUNC_ADD, 3'd5, 8'hA5, 16'd1, 16'd2);
    send_fields(pts_pkg::FUNC_ADD, 3'd2, 8'h5A, 16'd0, 16'd1);
    send_fields(pts_pkg::FUNC_TICK, 3'd0, 8'h00, 16'd0, 16'd0);
    // one-shot gains a second run
    send_fields(pts_pkg::FUNC_TICK, 3'd0, 8'h00, 16'd0, 16'd0);
    // one-shot removed, shift-in seen
    send_fields(pts_pkg::FUNC_DISP, 3'd0, 8'h00, 16'd0, 16'd0);
    send_fields(pts_pkg::FUNC_DISP, 3'd0, 8'h00, 16'd0, 16'd0);
    // fill the table with one-shots, then overflow it
    for (int k = 0; k < 6; k++) begin
      send_fields(pts_pkg::FUNC_ADD, 3'(k), 8'(8'h10 + k), 16'd0, 16'd0);
    end
    send_fields(pts_pkg::FUNC_TICK, 3'd0, 8'h00, 16'd0, 16'd0);
    // chain of one-shot removals
    send_fields(pts_pkg::FUNC_DISP, 3'd0, 8'h00, 16'd0, 16'd0);
    send_fields(pts_pkg::FUNC_ADD, 3'd0, 8'h77, 16'd0, 16'd3);
    // slot past the count, then two valid deletes
    send_fields(pts_pkg::FUNC_DEL, 3'd7, 8'h00, 16'd0, 16'd0);
    send_fields(pts_pkg::FUNC_DEL, 3'd0, 8'h00, 16'd0, 16'd0);
    send_fields(pts_pkg::FUNC_DEL, 3'd1, 8'h00, 16'd0, 16'd0);
    send_fields(pts_pkg::FUNC_DISP, 3'd0, 8'h00, 16'd0, 16'd0);
  endtask

  initial begin
    board          = new();
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    hold_req       = 1'b0;
    hold_left      = 0;
    cycles         = 0;
    send_idle_pct  = 6;
    recv_idle_pct  = 80;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // slow receiver
    run_directed();
    run_random(160);
    wait_drain();

    // slow sender
    send_idle_pct = 80;
    recv_idle_pct = 6;
    run_random(160);
    wait_drain();

    // full rate, starting under a long response hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    run_random(150);
    wait_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.expected_rsp_q.size() != 0) begin
      $error("%0d expected responses never arrived", board.expected_rsp_q.size());
      board.errors++;
    end
    $display("Requests: %0d add, %0d delete, %0d tick, %0d dispatch; %0d responses checked",
             board.n_req[pts_pkg::FUNC_ADD], board.n_req[pts_pkg::FUNC_DEL],
             board.n_req[pts_pkg::FUNC_TICK], board.n_req[pts_pkg::FUNC_DISP],
             board.n_rsp);
    $display("Task runs dispatched: %0d, mismatches: %0d, cycles: %0d",
             board.n_runs, board.errors, cycles);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
